// ===== design/sarp_pkg.sv =====
// ----------------------------------------------------------------------------
// sarp_pkg: shared types and constants for the servo angle ramp to pulse block
// Field widths, configuration register indexes, request modes, reset values,
// sequencer states and the divider request and response bundles.
// ----------------------------------------------------------------------------
package sarp_pkg;

  localparam int ANGLE_W     = 10;
  localparam int RAMP_W      = 11;
  localparam int PULSE_W     = 14;
  localparam int STEP_W      = 9;
  localparam int DELAY_W     = 16;
  localparam int SERVO_W     = 4;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 14;
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;

  localparam int DIV_W     = 24;
  localparam int DVSR_W    = 10;
  localparam int DIV_CNT_W = 5;

  localparam logic [MODE_W-1:0] MODE_SET  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RAMP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_SERVO  = 3'd4;

  localparam logic [ANGLE_W-1:0] RST_MIN_ANGLE  = 10'd0;
  localparam logic [ANGLE_W-1:0] RST_MAX_ANGLE  = 10'd180;
  localparam logic [PULSE_W-1:0] RST_PULSE_LOW  = 14'd500;
  localparam logic [PULSE_W-1:0] RST_PULSE_HIGH = 14'd2500;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MOD,
    ST_MAP,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quotient;
    logic [DVSR_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== design/sarp_div.sv =====
// ----------------------------------------------------------------------------
// sarp_div: shared restoring divider
// Unsigned division, one quotient bit per cycle; done pulses once when the
// quotient and remainder are ready and they hold until the next start.
// ----------------------------------------------------------------------------
module sarp_div (
  input  logic               clk,
  input  logic               rst,
  input  sarp_pkg::div_req_t req,
  output sarp_pkg::div_rsp_t rsp
);
  import sarp_pkg::*;

  logic                 run;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     dvd;
  logic [DVSR_W-1:0]    rem;
  logic [DVSR_W-1:0]    dsr;
  logic [DVSR_W:0]      rem_sh;
  logic                 fits;

  assign rem_sh = {rem, dvd[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (run) begin
      dvd <= {dvd[DIV_W-2:0], fits};
      rem <= fits ? DVSR_W'(rem_sh - {1'b0, dsr}) : rem_sh[DVSR_W-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = dvd;
  assign rsp.remainder = rem;

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !run)
    else $error("divider done while still running");
  a_start_idle: assert property (@(posedge clk) disable iff (rst) req.start |-> !run)
    else $error("divider started while busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst) done |-> rem < dsr)
    else $error("divider remainder not below divisor");

endmodule

// ===== design/servo_angle_ramp_to_pulse.sv =====
// ----------------------------------------------------------------------------
// servo_angle_ramp_to_pulse: servo PWM compare generator with stepped ramp
// Clamps an angle to the configured range, maps it onto a compare value and
// steps ramps on tick beats, one result beat per request beat.
//
//   port group   dir   beat content
//   s_*          in    request: tuser mode, tdata servo/angles/step/delay
//   m_*          out   result: compare, written flag, angle, busy flag
//   cfg_*        in    register write, index and data, no read-back
//
// Path: a set or a ramp step takes one divider pass for the map, a ramp
// start takes a modulo pass plus a map pass, and a beat that writes no
// compare value goes from decode straight to output; with an empty or
// inverted angle range the map pass is skipped.
// Reset: synchronous; registers return to their defaults, no ramp running.
// Stalls: s_tready is high only between requests; a finished result waits
// in the output register and the next request is taken while it waits.
// ----------------------------------------------------------------------------
module servo_angle_ramp_to_pulse (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [3:0] servo_number, [13:4] dest_angle, [23:14] start_angle,
  // [32:24] step_size, [48:33] step_delay
  input  logic [sarp_pkg::IN_TDATA_W-1:0]     s_tdata,
  // [1:0] mode
  input  logic [sarp_pkg::IN_TUSER_W-1:0]     s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [13:0] pulse_compare, [14] compare_written, [24:15] commanded_angle,
  // [25] ramp_busy
  output logic [sarp_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                cfg_we,
  input  logic [sarp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sarp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sarp_pkg::*;

  state_t state, state_next;

  // configuration
  logic signed [ANGLE_W-1:0] min_angle, max_angle;
  logic [PULSE_W-1:0]        pulse_low, pulse_high;
  logic [SERVO_W-1:0]        own_servo_number;

  // captured request
  logic [MODE_W-1:0]         in_mode;
  logic [SERVO_W-1:0]        in_servo;
  logic signed [ANGLE_W-1:0] in_tgt, in_start;
  logic [STEP_W-1:0]         in_step;
  logic [DELAY_W-1:0]        in_delay;

  // ramp state
  logic signed [RAMP_W-1:0]  ramp_angle, ramp_goal;
  logic [STEP_W-1:0]         ramp_step;
  logic                      ramp_down;
  logic [DELAY_W-1:0]        delay_reload, delay_left;
  logic                      busy_flag;
  logic [PULSE_W-1:0]        last_compare;
  logic                      written;

  // map operands
  logic [DVSR_W-1:0]         off_q, span_q;
  logic [PULSE_W-1:0]        mag_q;
  logic                      neg_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  function automatic logic signed [ANGLE_W-1:0] clamp_angle(
    input logic signed [RAMP_W-1:0]  a,
    input logic signed [ANGLE_W-1:0] lo,
    input logic signed [ANGLE_W-1:0] hi
  );
    logic signed [RAMP_W-1:0] r;
    r = a;
    if (r > RAMP_W'(hi)) r = RAMP_W'(hi);
    if (r < RAMP_W'(lo)) r = RAMP_W'(lo);
    return r[ANGLE_W-1:0];
  endfunction

  // decode terms
  logic                      mine;
  logic signed [RAMP_W-1:0]  diff;
  logic [ANGLE_W-1:0]        travel;
  logic                      no_move;
  logic [DELAY_W-1:0]        delay_dec;
  logic signed [RAMP_W:0]    ang12, goal12, n_up, n_dn;
  logic signed [RAMP_W-1:0]  next_angle;
  logic                      step_now;
  logic [ANGLE_W-1:0]        move;
  logic signed [RAMP_W-1:0]  start11;
  logic signed [ANGLE_W-1:0] cur_clamp;
  logic signed [RAMP_W-1:0]  off_full, span_full;
  logic signed [PULSE_W:0]   pdiff;
  logic                      range_ok;
  logic [DIV_W-1:0]          prod;
  logic [DIV_W-1:0]          q_signed;

  assign mine      = in_servo == own_servo_number;
  assign diff      = RAMP_W'(in_tgt) - RAMP_W'(in_start);
  assign travel    = diff[RAMP_W-1] ? ANGLE_W'(-diff) : diff[ANGLE_W-1:0];
  assign no_move   = (in_step == '0) || (travel < {1'b0, in_step});
  assign delay_dec = (delay_left != '0) ? delay_left - 1'b1 : '0;

  assign ang12      = (RAMP_W + 1)'(ramp_angle);
  assign goal12     = (RAMP_W + 1)'(ramp_goal);
  assign n_up       = ang12 + $signed({3'b000, ramp_step});
  assign n_dn       = ang12 - $signed({3'b000, ramp_step});
  assign next_angle = ramp_down ? ((n_dn < goal12) ? ramp_goal : n_dn[RAMP_W-1:0])
                                : ((n_up > goal12) ? ramp_goal : n_up[RAMP_W-1:0]);
  assign step_now   = busy_flag && (delay_dec == '0) && (ramp_angle != ramp_goal);

  assign move    = {1'b0, in_step} + {1'b0, div_rsp.remainder[STEP_W-1:0]};
  assign start11 = RAMP_W'(in_start);

  assign cur_clamp = clamp_angle(ramp_angle, min_angle, max_angle);
  assign off_full  = RAMP_W'(cur_clamp) - RAMP_W'(min_angle);
  assign span_full = RAMP_W'(max_angle) - RAMP_W'(min_angle);
  assign range_ok  = max_angle > min_angle;
  assign pdiff     = $signed({1'b0, pulse_high}) - $signed({1'b0, pulse_low});
  assign prod      = off_q * mag_q;
  assign q_signed  = neg_q ? -div_rsp.quotient : div_rsp.quotient;

  assign s_tready = state == ST_IDLE;

  sarp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = prod;
    div_req.divisor  = span_q;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (in_mode == MODE_SET && mine) begin
          state_next = ST_MAP;
        end else if (in_mode == MODE_RAMP && mine) begin
          if (no_move) begin
            state_next = ST_OUT;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(travel);
            div_req.divisor  = DVSR_W'(in_step);
            state_next       = ST_MOD;
          end
        end else if (in_mode == MODE_TICK && step_now) begin
          state_next = ST_MAP;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_MOD: begin
        if (div_rsp.done) state_next = ST_MAP;
      end
      ST_MAP: begin
        state_next = range_ok ? ST_MUL : ST_OUT;
      end
      ST_MUL: begin
        div_req.start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_angle        <= RST_MIN_ANGLE;
      max_angle        <= RST_MAX_ANGLE;
      pulse_low        <= RST_PULSE_LOW;
      pulse_high       <= RST_PULSE_HIGH;
      own_servo_number <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_ANGLE:  min_angle        <= cfg_data[ANGLE_W-1:0];
        REG_MAX_ANGLE:  max_angle        <= cfg_data[ANGLE_W-1:0];
        REG_PULSE_LOW:  pulse_low        <= cfg_data[PULSE_W-1:0];
        REG_PULSE_HIGH: pulse_high       <= cfg_data[PULSE_W-1:0];
        REG_OWN_SERVO:  own_servo_number <= cfg_data[SERVO_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture and map operands
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      in_mode  <= s_tuser[1:0];
      in_servo <= s_tdata[3:0];
      in_tgt   <= s_tdata[13:4];
      in_start <= s_tdata[23:14];
      in_step  <= s_tdata[32:24];
      in_delay <= s_tdata[48:33];
    end
    if (state == ST_MAP) begin
      off_q  <= off_full[DVSR_W-1:0];
      span_q <= span_full[DVSR_W-1:0];
      neg_q  <= pdiff[PULSE_W];
      mag_q  <= pdiff[PULSE_W] ? PULSE_W'(-pdiff) : pdiff[PULSE_W-1:0];
    end
  end

  // ramp state and result
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_angle   <= '0;
      ramp_goal    <= '0;
      ramp_step    <= '0;
      ramp_down    <= 1'b0;
      delay_reload <= '0;
      delay_left   <= '0;
      busy_flag    <= 1'b0;
      last_compare <= RST_PULSE_LOW;
      written      <= 1'b0;
      m_tvalid     <= 1'b0;
      m_tdata      <= '0;
    end else begin
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_DECODE: begin
          written <= (in_mode == MODE_SET && mine) || (in_mode == MODE_TICK && step_now);
          if (in_mode == MODE_SET && mine) begin
            busy_flag  <= 1'b0;
            delay_left <= '0;
            ramp_angle <= RAMP_W'(clamp_angle(RAMP_W'(in_tgt), min_angle, max_angle));
          end else if (in_mode == MODE_RAMP && mine) begin
            if (no_move) begin
              busy_flag  <= 1'b0;
              delay_left <= '0;
            end
          end else if (in_mode == MODE_TICK && busy_flag) begin
            if (delay_dec != '0) begin
              delay_left <= delay_dec;
            end else if (ramp_angle == ramp_goal) begin
              delay_left <= '0;
              busy_flag  <= 1'b0;
            end else begin
              ramp_angle <= next_angle;
              delay_left <= delay_reload;
            end
          end
        end
        ST_MOD: begin
          if (div_rsp.done) begin
            ramp_down    <= diff[RAMP_W-1];
            ramp_goal    <= RAMP_W'(in_tgt);
            ramp_step    <= in_step;
            delay_reload <= in_delay;
            delay_left   <= in_delay;
            busy_flag    <= 1'b1;
            written      <= 1'b1;
            ramp_angle   <= diff[RAMP_W-1] ? start11 - $signed({1'b0, move})
                                           : start11 + $signed({1'b0, move});
          end
        end
        ST_MAP: begin
          if (!range_ok) last_compare <= pulse_low;
        end
        ST_DIV: begin
          if (div_rsp.done) last_compare <= pulse_low + q_signed[PULSE_W-1:0];
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {6'd0, busy_flag, cur_clamp, written, last_compare};
          end
        end
        default: ;
      endcase
    end
  end

  a_busy_step: assert property (@(posedge clk) disable iff (rst)
    busy_flag |-> ramp_step != '0)
    else $error("ramp running with zero step");
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_MOD || state == ST_DIV))
    else $error("divider result arrived outside a wait state");
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == ST_DECODE)
    else $error("accepted beat not decoded");
  a_map_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> span_q != '0)
    else $error("map started with empty angle span");

endmodule

// ===== tb/sarp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sarp_checker: scoreboard for the servo angle ramp to pulse block
// Watches the request, result and register write ports. Keeps its own copy
// of the registers and the ramp state, predicts one result beat per
// accepted request beat, and compares every accepted result beat, field by
// field, with the oldest prediction.
// ----------------------------------------------------------------------------
module sarp_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [sarp_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic [sarp_pkg::IN_TUSER_W-1:0]  s_tuser,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [sarp_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                             cfg_we,
  input  logic [sarp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sarp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               errors,
  output int                               pending,
  output int                               checked,
  output int                               ramp_ends
);
  import sarp_pkg::*;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [SERVO_W-1:0] servo;
    logic [ANGLE_W-1:0] target;
    logic [ANGLE_W-1:0] start;
    logic [STEP_W-1:0]  step;
    logic [DELAY_W-1:0] delay;
  } servo_req_t;

  typedef struct packed {
    logic [PULSE_W-1:0] compare;
    logic               written;
    logic [ANGLE_W-1:0] angle;
    logic               busy;
  } servo_res_t;

  // register copy
  logic signed [ANGLE_W-1:0] lim_lo;
  logic signed [ANGLE_W-1:0] lim_hi;
  logic [PULSE_W-1:0]        pw_lo;
  logic [PULSE_W-1:0]        pw_hi;
  logic [SERVO_W-1:0]        my_servo;

  // ramp state
  logic signed [RAMP_W-1:0]  cur_angle;
  logic signed [RAMP_W-1:0]  goal_angle;
  logic [STEP_W-1:0]         stride;
  logic                      descending;
  logic [DELAY_W-1:0]        dwell_reload;
  logic [DELAY_W-1:0]        dwell_left;
  logic                      ramping;
  logic [PULSE_W-1:0]        cur_compare;

  servo_res_t want_q[$];
  int n_in = 0;
  int n_out = 0;

  initial errors = 0;
  initial ramp_ends = 0;

  assign pending = n_in - n_out;
  assign checked = n_out;

  function automatic int clamp_deg(input int deg);
    int lo;
    int hi;
    lo = lim_lo;
    hi = lim_hi;
    if (deg > hi) deg = hi;
    if (deg < lo) deg = lo;
    return deg;
  endfunction

  function automatic logic [PULSE_W-1:0] pulse_for(input int deg);
    longint c;
    longint lo;
    longint hi;
    longint pl;
    longint ph;
    longint v;
    lo = lim_lo;
    hi = lim_hi;
    pl = pw_lo;
    ph = pw_hi;
    c = clamp_deg(deg);
    v = pl;
    if (hi > lo) v = (c - lo) * (ph - pl) / (hi - lo) + pl;
    return PULSE_W'(v);
  endfunction

  task automatic servo_step(input servo_req_t rq, output servo_res_t rs);
    int  tgt;
    int  org;
    int  d;
    int  travel;
    int  rem;
    int  st;
    int  a;
    int  g;
    int  nxt;
    logic mine;
    logic wr;
    tgt  = $signed(rq.target);
    org  = $signed(rq.start);
    mine = (rq.servo == my_servo);
    wr   = 1'b0;
    if (rq.mode == MODE_SET && mine) begin
      ramping     = 1'b0;
      dwell_left  = '0;
      cur_angle   = RAMP_W'(clamp_deg(tgt));
      cur_compare = pulse_for(cur_angle);
      wr          = 1'b1;
    end else if (rq.mode == MODE_RAMP && mine) begin
      d      = tgt - org;
      travel = (d < 0) ? -d : d;
      st     = rq.step;
      if (st == 0 || travel < st) begin
        ramping    = 1'b0;
        dwell_left = '0;
      end else begin
        rem          = travel % st;
        descending   = (d < 0);
        goal_angle   = RAMP_W'(tgt);
        stride       = rq.step;
        dwell_reload = rq.delay;
        a            = descending ? org - (st + rem) : org + (st + rem);
        cur_angle    = RAMP_W'(a);
        cur_compare  = pulse_for(a);
        dwell_left   = dwell_reload;
        ramping      = 1'b1;
        wr           = 1'b1;
      end
    end else if (rq.mode == MODE_TICK && ramping) begin
      if (dwell_left != '0) dwell_left = dwell_left - 1'b1;
      if (dwell_left == '0) begin
        if (cur_angle == goal_angle) begin
          ramping = 1'b0;
          ramp_ends++;
        end else begin
          a  = cur_angle;
          g  = goal_angle;
          st = stride;
          if (descending) begin
            nxt = a - st;
            if (nxt < g) nxt = g;
          end else begin
            nxt = a + st;
            if (nxt > g) nxt = g;
          end
          cur_angle   = RAMP_W'(nxt);
          cur_compare = pulse_for(nxt);
          dwell_left  = dwell_reload;
          wr          = 1'b1;
        end
      end
    end
    rs.compare = cur_compare;
    rs.written = wr;
    rs.angle   = ANGLE_W'(clamp_deg(cur_angle));
    rs.busy    = ramping;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < 40)
      $display("%0t ns: result beat %0d: %s is %0d, expected %0d", $time, n_out, what, got,
               want);
    errors++;
  endtask

  always @(posedge clk) begin
    servo_req_t rq;
    servo_res_t rs;
    servo_res_t got;
    servo_res_t want;
    if (rst) begin
      lim_lo       = RST_MIN_ANGLE;
      lim_hi       = RST_MAX_ANGLE;
      pw_lo        = RST_PULSE_LOW;
      pw_hi        = RST_PULSE_HIGH;
      my_servo     = '0;
      cur_angle    = '0;
      goal_angle   = '0;
      stride       = '0;
      descending   = 1'b0;
      dwell_reload = '0;
      dwell_left   = '0;
      ramping      = 1'b0;
      cur_compare  = RST_PULSE_LOW;
      want_q.delete();
      n_in  <= 0;
      n_out <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_ANGLE:  lim_lo   = cfg_data[ANGLE_W-1:0];
          REG_MAX_ANGLE:  lim_hi   = cfg_data[ANGLE_W-1:0];
          REG_PULSE_LOW:  pw_lo    = cfg_data[PULSE_W-1:0];
          REG_PULSE_HIGH: pw_hi    = cfg_data[PULSE_W-1:0];
          REG_OWN_SERVO:  my_servo = cfg_data[SERVO_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.compare = m_tdata[13:0];
        got.written = m_tdata[14];
        got.angle   = m_tdata[24:15];
        got.busy    = m_tdata[25];
        if (want_q.size() == 0) begin
          report_mismatch("beat with nothing outstanding, data", int'(m_tdata), 0);
        end else begin
          want = want_q.pop_front();
          if (got.compare !== want.compare)
            report_mismatch("pulse_compare", got.compare, want.compare);
          if (got.written !== want.written)
            report_mismatch("compare_written", got.written, want.written);
          if (got.angle !== want.angle)
            report_mismatch("commanded_angle", $signed(got.angle), $signed(want.angle));
          if (got.busy !== want.busy)
            report_mismatch("ramp_busy", got.busy, want.busy);
        end
        n_out <= n_out + 1;
      end
      if (s_tvalid && s_tready) begin
        rq.mode   = s_tuser;
        rq.servo  = s_tdata[3:0];
        rq.target = s_tdata[13:4];
        rq.start  = s_tdata[23:14];
        rq.step   = s_tdata[32:24];
        rq.delay  = s_tdata[48:33];
        servo_step(rq, rs);
        want_q.push_back(rs);
        n_in <= n_in + 1;
      end
    end
  end

endmodule

// ===== tb/tb_servo_angle_ramp_to_pulse.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_servo_angle_ramp_to_pulse: testbench for the servo angle ramp to pulse
// Drives a directed set of requests under the reset registers, then random
// ramp episodes, set commands and noise under several register settings,
// extremes and inverted or empty angle ranges among them. The sender works in
// bursts with random gaps, the receiver stalls on changing patterns, and the
// checker compares every result beat against its own prediction.
// ----------------------------------------------------------------------------
module tb_servo_angle_ramp_to_pulse;
  import sarp_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_BEATS = 90;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int errors;
  int pending;
  int checked;
  int ramp_ends;

  int       cycles = 0;
  int       n_sent = 0;
  int       n_settings = 1;
  int       burst_left = 0;
  int       own = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  servo_angle_ramp_to_pulse u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sarp_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .ramp_ends (ramp_ends)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("no progress after %0d cycles, %0d beats outstanding", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: switch between randomly chosen stall patterns
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(100, 600);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= ($urandom_range(0, 1) == 0);
      RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
      default:   m_tready <= ((rx_left % 16) < 10);
    endcase
  end

  function automatic int rand_angle();
    case ($urandom_range(0, 9))
      0: return -360;
      1: return 360;
      default: return int'($urandom_range(0, 720)) - 360;
    endcase
  endfunction

  function automatic int pick_servo();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 15);
    return own;
  endfunction

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_beat(input logic [MODE_W-1:0] mode, input int servo, input int tgt,
                           input int org, input int step, input int dly);
    pace();
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= IN_TDATA_W'({16'(dly), 9'(step), 10'(org), 10'(tgt), 4'(servo)});
    do @(posedge clk); while (!s_tready);
    n_sent++;
  endtask

  task automatic tick_beat();
    send_beat(MODE_TICK, $urandom_range(0, 15), rand_angle(), rand_angle(),
              $urandom_range(0, 360), $urandom_range(0, 65535));
  endtask

  task automatic noise_beat();
    logic [MODE_W-1:0] mode;
    mode = MODE_W'($urandom_range(0, 2));
    send_beat(mode, $urandom_range(0, 15), rand_angle(), rand_angle(),
              $urandom_range(0, 360), $urandom_range(0, 65535));
  endtask

  task automatic ramp_episode();
    int org;
    int tgt;
    int travel;
    int step;
    int dly;
    int ticks;
    int k;
    org    = rand_angle();
    tgt    = rand_angle();
    travel = (tgt > org) ? tgt - org : org - tgt;
    step   = (travel == 0) ? $urandom_range(1, 360) : travel / $urandom_range(1, 6);
    if (step < 1) step = 1;
    if (step > 360) step = 360;
    k = $urandom_range(0, 15);
    if (k == 0) step = 0;
    else if (k == 1) step = $urandom_range(0, 360);
    dly = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
    send_beat(MODE_RAMP, pick_servo(), tgt, org, step, dly);
    // ticks to finish the ramp, sometimes a few more, but never more than 40
    ticks = (step == 0) ? 1 : (travel / step) * ((dly > 1) ? dly : 1) + $urandom_range(0, 2);
    if (ticks > 40) ticks = 40;
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 39) == 0) noise_beat();
      else tick_beat();
    end
  endtask

  task automatic random_part(input int beats);
    int goal;
    int k;
    goal = n_sent + beats;
    while (n_sent < goal) begin
      k = $urandom_range(0, 9);
      if (k < 6) begin
        ramp_episode();
      end else if (k < 8) begin
        repeat ($urandom_range(1, 3))
          send_beat(MODE_SET, pick_servo(), rand_angle(), rand_angle(),
                    $urandom_range(0, 360), $urandom_range(0, 65535));
      end else begin
        noise_beat();
      end
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
  endtask

  task automatic configure(input int lo, input int hi, input int pl, input int ph,
                           input int servo);
    write_reg(REG_MIN_ANGLE, lo & 'h3FF);
    write_reg(REG_MAX_ANGLE, hi & 'h3FF);
    write_reg(REG_PULSE_LOW, pl);
    write_reg(REG_PULSE_HIGH, ph);
    write_reg(REG_OWN_SERVO, servo);
    cfg_we <= 1'b0;
    own = servo;
    n_settings++;
  endtask

  initial begin
    int lo;
    int hi;
    int t;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset registers: range 0..180 onto 500..2500, servo 0
    send_beat(MODE_TICK, 7, 0, 0, 0, 0);
    send_beat(MODE_SET, 0, 0, 0, 0, 0);
    send_beat(MODE_SET, 0, 180, 0, 0, 0);
    send_beat(MODE_SET, 0, 360, 0, 0, 0);
    send_beat(MODE_SET, 0, -360, 0, 0, 0);
    send_beat(MODE_SET, 0, 90, 0, 0, 0);
    send_beat(MODE_SET, 15, 45, 0, 0, 0);
    send_beat(MODE_UNUSED, 0, 120, 0, 30, 0);
    send_beat(MODE_RAMP, 0, 100, 0, 30, 1);
    repeat (4) send_beat(MODE_TICK, 9, 0, 0, 0, 0);
    send_beat(MODE_RAMP, 0, -20, 180, 60, 0);
    repeat (3) send_beat(MODE_TICK, 0, 0, 0, 0, 0);
    send_beat(MODE_RAMP, 0, 50, 50, 10, 0);
    send_beat(MODE_RAMP, 0, 60, 10, 0, 2);
    send_beat(MODE_RAMP, 0, 10, 0, 20, 0);
    send_beat(MODE_RAMP, 3, 170, 0, 10, 0);
    send_beat(MODE_RAMP, 0, 360, -360, 360, 65535);
    send_beat(MODE_TICK, 15, 0, 0, 0, 0);
    send_beat(MODE_SET, 0, 20, 0, 0, 0);
    send_beat(MODE_TICK, 0, 0, 0, 0, 0);

    drain();
    configure(-360, 360, 0, 10000, 15);
    random_part(PHASE_BEATS);

    // inverted range: everything clamps to the minimum
    drain();
    configure(100, -100, 10000, 0, 5);
    random_part(PHASE_BEATS);

    // empty range
    drain();
    configure(30, 30, 1234, 4321, 10);
    random_part(PHASE_BEATS);

    // falling pulse map
    drain();
    configure(-90, 90, 10000, 0, 0);
    random_part(PHASE_BEATS);

    drain();
    lo = rand_angle();
    hi = rand_angle();
    if (lo > hi) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    configure(lo, hi, $urandom_range(0, 10000), $urandom_range(0, 10000),
              $urandom_range(0, 15));
    random_part(PHASE_BEATS);

    drain();
    configure(rand_angle(), rand_angle(), $urandom_range(0, 10000), $urandom_range(0, 10000),
              $urandom_range(0, 15));
    random_part(PHASE_BEATS);

    drain();
    repeat (64) @(posedge clk);
    $display("%0d request beats under %0d register settings, %0d result beats checked",
             n_sent, n_settings, checked);
    $display("%0d ramps ran to completion, %0d mismatches", ramp_ends, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
